FILE: rtl/rph_pkg.sv
// Shared types, field widths and codes of the resident page hash table.
package rph_pkg;

    localparam int KIND_W   = 3;
    localparam int PROC_W   = 4;
    localparam int PAGE_W   = 20;
    localparam int CFG_W    = 11;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam int DEF_TABLE_DEPTH   = 1024;
    localparam int DEF_NUM_PROCESSES = 16;
    localparam int DEF_PAGE_BITS     = 20;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1023;

    typedef enum logic [KIND_W-1:0] {
        K_LOOKUP    = 3'd0,
        K_INSERT    = 3'd1,
        K_REMOVE    = 3'd2,
        K_SET_FLAG  = 3'd3,
        K_READ_FLAG = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_TOMB  = 2'd2
    } t_slot_st;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PROC_W-1:0] process_index;
        logic [PAGE_W-1:0] page_number;
        logic              flag_value;
    } t_cmd;

    typedef struct packed {
        logic                found;
        logic                flag_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  resident_count;
    } t_res;

endpackage

FILE: rtl/rph_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rph_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/rph_mod.sv
// Iterative remainder unit: page number modulo table size, two bits per cycle.
module rph_mod #(
    parameter int PAGE_BITS = 20,
    parameter int NW        = 11,
    parameter int IDX_W     = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [PAGE_BITS-1:0] i_dividend,
    input  logic [NW-1:0]        i_divisor,
    output logic                 o_done,
    output logic [IDX_W-1:0]     o_rem
);

    localparam int D_W    = PAGE_BITS + (PAGE_BITS % 2);
    localparam int STEPS  = D_W / 2;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [D_W-1:0]    r_dvd;
    logic [NW:0]       r_rem;
    logic [NW-1:0]     r_div;

    logic [D_W-1:0]    n_dvd;
    logic [NW:0]       n_rem;

    always_comb begin
        n_dvd = r_dvd;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[NW-1:0], n_dvd[D_W-1]};
            n_dvd = {n_dvd[D_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_div}) begin
                n_rem = n_rem - {1'b0, r_div};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                if (r_step == STEP_W'(STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= D_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[IDX_W-1:0];

endmodule

FILE: rtl/resident_page_hash_table_unit.sv
// Top level of the resident page hash table: command handling, probe sequencer, storage.
//
// One transaction at a time. For a nonzero page the remainder unit first
// computes the home slot, then the slot memory read port walks one slot per
// cycle, visiting from one slot up to the table size, and a final state
// writes back and registers the result. Page 0 skips the probe and goes
// straight to that final state.
// busy stays high until the result strobe cycle, so results are never lost even
// though the receiver cannot stall: o_res_valid is high for exactly one cycle.
// After reset the block clears all NUM_PROCESSES * TABLE_DEPTH slot memory entries,
// with busy high; table size writes are taken during that time.
module resident_page_hash_table_unit
    import rph_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int NUM_PROCESSES = DEF_NUM_PROCESSES,
    parameter int PAGE_BITS     = DEF_PAGE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_cmd             i_cmd,
    output logic             busy,
    output logic             o_res_valid,
    output t_res             o_res,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data
);

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int NW         = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W      = NW;
    localparam int P_W        = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int SLOT_DEPTH = NUM_PROCESSES * TABLE_DEPTH;
    localparam int ADDR_W     = $clog2(SLOT_DEPTH);
    localparam int PG_EXT     = (PAGE_BITS > PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int SLOT_W     = PAGE_BITS + 3;
    localparam int META_W     = CNT_W + 2;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_PROBE = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        t_slot_st             st;
        logic                 flag;
    } t_slot;

    typedef struct packed {
        logic             present;
        logic             zflag;
        logic [CNT_W-1:0] cnt;
    } t_meta;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_clr, n_clr;
    logic [CFG_W-1:0]     r_table_size;
    t_kind                r_kind, n_kind;
    logic [P_W-1:0]       r_p, n_p;
    logic [PAGE_BITS-1:0] r_page, n_page;
    logic                 r_fv, n_fv;
    logic                 r_zero, n_zero;
    logic [ADDR_W-1:0]    r_base, n_base;
    logic [NW-1:0]        r_n, n_n;
    logic [IDX_W-1:0]     r_cur, n_cur;
    logic [NW-1:0]        r_cnt, n_cnt;
    logic                 r_tomb_vld, n_tomb_vld;
    logic [IDX_W-1:0]     r_tomb, n_tomb;
    logic                 r_hit, n_hit;
    logic                 r_hit_flag, n_hit_flag;
    logic                 r_sel_vld, n_sel_vld;
    logic [IDX_W-1:0]     r_sel, n_sel;
    logic                 r_res_valid, n_res_valid;
    t_res                 r_res, n_res;

    logic                 accept;
    logic [P_W-1:0]       p_wrap;
    logic [PG_EXT-1:0]    page_ext;
    logic [PAGE_BITS-1:0] page_in;
    logic [NW-1:0]        eff_n;
    logic                 mod_start;
    logic                 mod_done;
    logic [IDX_W-1:0]     mod_rem;
    logic [NW-1:0]        cur_p1;
    logic [IDX_W-1:0]     nxt_idx;

    logic                 slot_we, slot_re;
    logic [ADDR_W-1:0]    slot_waddr, slot_raddr;
    t_slot                slot_wdata, slot_rdata;
    logic                 meta_we, meta_re;
    logic [P_W-1:0]       meta_waddr;
    t_meta                meta_wdata, meta_rdata;

    assign accept   = start && (r_state == S_IDLE);
    assign page_ext = PG_EXT'(i_cmd.page_number);
    assign page_in  = page_ext[PAGE_BITS-1:0];
    assign mod_start = accept && (page_in != '0);

    always_comb begin
        p_wrap = '0;
        for (int i = 0; i < 2 ** PROC_W; i++) begin
            if (i_cmd.process_index == PROC_W'(i)) begin
                p_wrap = P_W'(i % NUM_PROCESSES);
            end
        end
    end

    always_comb begin
        if (r_table_size == '0) begin
            eff_n = NW'(1);
        end else if (32'(r_table_size) > 32'(TABLE_DEPTH)) begin
            eff_n = NW'(TABLE_DEPTH);
        end else begin
            eff_n = NW'(r_table_size);
        end
    end

    assign cur_p1  = NW'(r_cur) + NW'(1);
    assign nxt_idx = (cur_p1 == r_n) ? '0 : cur_p1[IDX_W-1:0];

    rph_mod #(
        .PAGE_BITS (PAGE_BITS),
        .NW        (NW),
        .IDX_W     (IDX_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (page_in),
        .i_divisor  (eff_n),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    rph_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_we),
        .i_wr_addr (slot_waddr),
        .i_wr_data (slot_wdata),
        .i_rd_en   (slot_re),
        .i_rd_addr (slot_raddr),
        .o_rd_data (slot_rdata)
    );

    rph_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_PROCESSES)
    ) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (meta_we),
        .i_wr_addr (meta_waddr),
        .i_wr_data (meta_wdata),
        .i_rd_en   (meta_re),
        .i_rd_addr (p_wrap),
        .o_rd_data (meta_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_kind      = r_kind;
        n_p         = r_p;
        n_page      = r_page;
        n_fv        = r_fv;
        n_zero      = r_zero;
        n_base      = r_base;
        n_n         = r_n;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_tomb_vld  = r_tomb_vld;
        n_tomb      = r_tomb;
        n_hit       = r_hit;
        n_hit_flag  = r_hit_flag;
        n_sel_vld   = r_sel_vld;
        n_sel       = r_sel;
        n_res_valid = 1'b0;
        n_res       = r_res;

        slot_we    = 1'b0;
        slot_waddr = r_base + ADDR_W'(r_sel);
        slot_wdata = '{page: r_page, st: SLOT_USED, flag: 1'b0};
        slot_re    = 1'b0;
        slot_raddr = r_base + ADDR_W'(nxt_idx);
        meta_we    = 1'b0;
        meta_waddr = r_p;
        meta_wdata = meta_rdata;
        meta_re    = accept;

        unique case (r_state)
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                slot_wdata = '{page: '0, st: SLOT_EMPTY, flag: 1'b0};
                if (32'(r_clr) < NUM_PROCESSES) begin
                    meta_we    = 1'b1;
                    meta_waddr = r_clr[P_W-1:0];
                    meta_wdata = '0;
                end
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(SLOT_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.kind) inside
                        K_INSERT, K_REMOVE, K_SET_FLAG, K_READ_FLAG: begin
                            n_kind = t_kind'(i_cmd.kind);
                        end
                        default: begin
                            n_kind = K_LOOKUP;
                        end
                    endcase
                    n_p        = p_wrap;
                    n_page     = page_in;
                    n_fv       = i_cmd.flag_value;
                    n_zero     = (page_in == '0);
                    n_base     = ADDR_W'(p_wrap) * ADDR_W'(TABLE_DEPTH);
                    n_n        = eff_n;
                    n_tomb_vld = 1'b0;
                    n_hit      = 1'b0;
                    n_sel_vld  = 1'b0;
                    n_state    = (page_in == '0) ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                if (mod_done) begin
                    slot_re    = 1'b1;
                    slot_raddr = r_base + ADDR_W'(mod_rem);
                    n_cur      = mod_rem;
                    n_cnt      = NW'(1);
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                if (slot_rdata.st == SLOT_EMPTY) begin
                    n_sel_vld = 1'b1;
                    n_sel     = r_tomb_vld ? r_tomb : r_cur;
                    n_state   = S_FIN;
                end else if (slot_rdata.st == SLOT_USED && slot_rdata.page == r_page) begin
                    n_hit      = 1'b1;
                    n_hit_flag = slot_rdata.flag;
                    n_sel      = r_cur;
                    n_state    = S_FIN;
                end else begin
                    if (slot_rdata.st != SLOT_USED && !r_tomb_vld) begin
                        n_tomb_vld = 1'b1;
                        n_tomb     = r_cur;
                    end
                    if (r_cnt == r_n) begin
                        n_sel_vld = n_tomb_vld;
                        n_sel     = n_tomb;
                        n_state   = S_FIN;
                    end else begin
                        slot_re = 1'b1;
                        n_cur   = nxt_idx;
                        n_cnt   = r_cnt + NW'(1);
                    end
                end
            end
            S_FIN: begin
                n_res_valid            = 1'b1;
                n_res.found            = 1'b0;
                n_res.flag_out         = 1'b0;
                n_res.status           = ST_OK;
                meta_we                = 1'b1;
                if (r_zero) begin
                    unique case (r_kind)
                        K_INSERT: begin
                            meta_wdata.present = 1'b1;
                            meta_wdata.zflag   = meta_rdata.present && meta_rdata.zflag;
                            n_res.found        = 1'b1;
                            n_res.flag_out     = meta_rdata.present && meta_rdata.zflag;
                        end
                        K_REMOVE: begin
                            meta_wdata.present = 1'b0;
                            meta_wdata.zflag   = 1'b0;
                            if (!meta_rdata.present) begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        end
                        K_SET_FLAG: begin
                            if (meta_rdata.present) begin
                                meta_wdata.zflag = r_fv;
                                n_res.found      = 1'b1;
                                n_res.flag_out   = r_fv;
                            end else begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (meta_rdata.present) begin
                                n_res.found    = 1'b1;
                                n_res.flag_out = meta_rdata.zflag;
                            end else begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        end
                    endcase
                end else begin
                    unique case (r_kind)
                        K_INSERT: begin
                            if (r_hit) begin
                                n_res.found    = 1'b1;
                                n_res.flag_out = r_hit_flag;
                            end else if (r_sel_vld) begin
                                slot_we        = 1'b1;
                                meta_wdata.cnt = meta_rdata.cnt + CNT_W'(1);
                                n_res.found    = 1'b1;
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        K_REMOVE: begin
                            if (r_hit) begin
                                slot_we         = 1'b1;
                                slot_wdata.st   = SLOT_TOMB;
                                if (meta_rdata.cnt != '0) begin
                                    meta_wdata.cnt = meta_rdata.cnt - CNT_W'(1);
                                end
                            end else begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        end
                        K_SET_FLAG: begin
                            if (r_hit) begin
                                slot_we         = 1'b1;
                                slot_wdata.flag = r_fv;
                                n_res.found     = 1'b1;
                                n_res.flag_out  = r_fv;
                            end else begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (r_hit) begin
                                n_res.found    = 1'b1;
                                n_res.flag_out = r_hit_flag;
                            end else begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
                n_res.resident_count = COUNT_W'(meta_wdata.cnt);
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_table_size <= TABLE_SIZE_RST;
            r_res_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_res_valid <= n_res_valid;
            if (i_cfg_wr_en) begin
                r_table_size <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_p        <= n_p;
        r_page     <= n_page;
        r_fv       <= n_fv;
        r_zero     <= n_zero;
        r_base     <= n_base;
        r_n        <= n_n;
        r_cur      <= n_cur;
        r_cnt      <= n_cnt;
        r_tomb_vld <= n_tomb_vld;
        r_tomb     <= n_tomb;
        r_hit      <= n_hit;
        r_hit_flag <= n_hit_flag;
        r_sel_vld  <= n_sel_vld;
        r_sel      <= n_sel;
        r_res      <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
